@@ rtl/core/mm_pkg.sv @@
// ----------------------------------------------------------------------------
// mm_pkg
// Shared constants, types and helper functions for the fixed-point matrix
// multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
  localparam int SAT_W  = (ACC_W > 32) ? ACC_W : 33;

  localparam int ACT_W  = 2;
  localparam int POS_W  = 3;
  localparam int DIM_W  = 4;
  localparam int REG_W  = 2;
  localparam int VAL_W  = 16;
  localparam int OUT_W  = 32;

  localparam logic [ACT_W-1:0] ACT_LEFT    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RIGHT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  localparam logic [REG_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [REG_W-1:0] REG_RIGHT_COLS = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // Returns the last index for a dimension register, with zero read as one
  // and anything above the store size read as the store size.
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
    logic [IDX_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (int'(d) > MAX_DIM) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(d - 1'b1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

endpackage

@@ rtl/core/mm_ram.sv @@
// ----------------------------------------------------------------------------
// mm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mm_mac.sv @@
// ----------------------------------------------------------------------------
// mm_mac
// Shared multiply-accumulate unit: one registered product stage, one
// accumulate stage, and saturation of the sum to a signed 32-bit result.
// ----------------------------------------------------------------------------
module mm_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mm_pkg::mac_ctl_t                    ctl_i,
  input  logic signed [mm_pkg::ELEM_WIDTH-1:0] a_i,
  input  logic signed [mm_pkg::ELEM_WIDTH-1:0] b_i,
  output logic signed [mm_pkg::OUT_W-1:0]     sum_o,
  output logic                                done_o
);

  import mm_pkg::*;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(2147483647);
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);

  mac_ctl_t                  prod_ctl_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic                      done_q;
  logic signed [SAT_W-1:0]  wide;

  always_comb begin
    if (prod_ctl_q.first) begin
      acc_d = ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_ctl_q <= '0;
      done_q     <= 1'b0;
    end else begin
      prod_ctl_q <= ctl_i;
      done_q     <= prod_ctl_q.valid && prod_ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= a_i * b_i;
    end
    if (prod_ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    wide = SAT_W'(acc_q);
    if (wide > SAT_MAX) begin
      sum_o = SAT_MAX[OUT_W-1:0];
    end else if (wide < SAT_MIN) begin
      sum_o = SAT_MIN[OUT_W-1:0];
    end else begin
      sum_o = wide[OUT_W-1:0];
    end
  end

  assign done_o = done_q;

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(prod_ctl_q.valid) && $past(prod_ctl_q.last))
    else $error("mm_mac: done without a final product");

  a_first_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.valid && ctl_i.first) |-> !prod_ctl_q.valid || prod_ctl_q.last)
    else $error("mm_mac: new sum started inside a running sum");

endmodule

@@ rtl/core/matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply
// Fixed-point matrix multiply with two element stores and one shared
// multiply-accumulate unit stepped by a small sequencer.
//
//   Channel  Handshake               Carries
//   in       in_valid_i / in_stall_o action, row, column, element value
//   out      out_valid_o / out_stall_i row, column, saturated sum, last
//   cfg      cfg_valid_i / cfg_ready_o register index, 4-bit data
//
// A compute request produces each product element from inner_size store
// reads through the one read port of each store, then the multiplier,
// accumulator and output stages, and waits while the output is stalled.
// The input is stalled for the whole compute request. Reset clears control
// state only; the stores hold undefined data until written.
// ----------------------------------------------------------------------------
module matrix_multiply (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mm_pkg::ACT_W-1:0]         action_i,
  input  logic [mm_pkg::POS_W-1:0]         row_index_i,
  input  logic [mm_pkg::POS_W-1:0]         col_index_i,
  input  logic signed [mm_pkg::VAL_W-1:0]  elem_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mm_pkg::POS_W-1:0]         out_row_o,
  output logic [mm_pkg::POS_W-1:0]         out_col_o,
  output logic signed [mm_pkg::OUT_W-1:0]  out_value_o,
  output logic                             last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mm_pkg::REG_W-1:0]         cfg_index_i,
  input  logic [mm_pkg::DIM_W-1:0]         cfg_data_i
);

  import mm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [DIM_W-1:0]  left_rows_q;
  logic [DIM_W-1:0]  inner_size_q;
  logic [DIM_W-1:0]  right_cols_q;
  logic [IDX_W-1:0]  r_q;
  logic [IDX_W-1:0]  c_q;
  logic [IDX_W-1:0]  k_q;
  logic [IDX_W-1:0]  r_last_q;
  logic [IDX_W-1:0]  c_last_q;
  logic [IDX_W-1:0]  k_last_q;
  mac_ctl_t          rd_ctl_q;
  mac_ctl_t          issue_ctl;
  logic              out_valid_q;
  logic [POS_W-1:0]  out_row_q;
  logic [POS_W-1:0]  out_col_q;
  logic signed [OUT_W-1:0] out_value_q;
  logic              out_last_q;

  logic              in_accept;
  logic              in_range;
  logic              left_we;
  logic              right_we;
  logic [ADDR_W-1:0] waddr;
  logic [ELEM_WIDTH-1:0] wdata;
  logic [ELEM_WIDTH-1:0] left_rdata;
  logic [ELEM_WIDTH-1:0] right_rdata;
  logic signed [OUT_W-1:0] mac_sum;
  logic              mac_done;
  logic              out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign in_range = (int'(row_index_i) < MAX_DIM) && (int'(col_index_i) < MAX_DIM);
  assign waddr    = addr_of(IDX_W'(row_index_i), IDX_W'(col_index_i));
  assign wdata    = ELEM_WIDTH'(elem_value_i);
  assign left_we  = in_accept && in_range && (action_i == ACT_LEFT);
  assign right_we = in_accept && in_range && (action_i == ACT_RIGHT);

  assign issue_ctl.valid = (state_q == ST_ISSUE);
  assign issue_ctl.first = (k_q == '0);
  assign issue_ctl.last  = (k_q == k_last_q);

  assign out_free = !out_valid_q || !out_stall_i;

  mm_ram #(
    .WIDTH(ELEM_WIDTH),
    .DEPTH(DEPTH)
  ) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (left_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(addr_of(r_q, k_q)),
    .rdata_o(left_rdata)
  );

  mm_ram #(
    .WIDTH(ELEM_WIDTH),
    .DEPTH(DEPTH)
  ) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (right_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(addr_of(k_q, c_q)),
    .rdata_o(right_rdata)
  );

  mm_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (rd_ctl_q),
    .a_i   (left_rdata),
    .b_i   (right_rdata),
    .sum_o (mac_sum),
    .done_o(mac_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_rows_q  <= DIM_RESET;
      inner_size_q <= DIM_RESET;
      right_cols_q <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LEFT_ROWS:  left_rows_q  <= cfg_data_i;
        REG_INNER_SIZE: inner_size_q <= cfg_data_i;
        REG_RIGHT_COLS: right_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q <= '0;
    end else begin
      rd_ctl_q <= issue_ctl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      r_last_q    <= '0;
      c_last_q    <= '0;
      k_last_q    <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && (action_i == ACT_COMPUTE)) begin
            r_q      <= '0;
            c_q      <= '0;
            k_q      <= '0;
            r_last_q <= dim_last(left_rows_q);
            c_last_q <= dim_last(right_cols_q);
            k_last_q <= dim_last(inner_size_q);
            state_q  <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_q == k_last_q) begin
            k_q     <= '0;
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_row_q   <= POS_W'(r_q);
            out_col_q   <= POS_W'(c_q);
            out_value_q <= mac_sum;
            out_last_q  <= (r_q == r_last_q) && (c_q == c_last_q);
            if (c_q == c_last_q) begin
              c_q <= '0;
              if (r_q == r_last_q) begin
                r_q     <= '0;
                state_q <= ST_IDLE;
              end else begin
                r_q     <= r_q + 1'b1;
                state_q <= ST_ISSUE;
              end
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= ST_ISSUE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign last_o      = out_last_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == ST_WAIT)
    else $error("matrix_multiply: sum finished outside the wait state");

  a_emit_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> $past(state_q) == ST_WAIT || $past(state_q) == ST_EMIT)
    else $error("matrix_multiply: emit entered without a finished sum");

  a_counters_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> r_q <= r_last_q && c_q <= c_last_q && k_q <= k_last_q)
    else $error("matrix_multiply: loop counter past its limit");

  a_no_write_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_we || right_we) |-> state_q == ST_IDLE && !rd_ctl_q.valid)
    else $error("matrix_multiply: store written during a compute request");

endmodule

@@ bench/product_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// product_checker
// Watches the load, configuration and result channels of matrix_multiply.
// It keeps its own copy of both element stores and of the three dimension
// registers, works out every product element when a compute request is
// accepted, and compares each accepted result field by field in order.
// ----------------------------------------------------------------------------
module product_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [mm_pkg::ACT_W-1:0]         action_i,
  input  logic [mm_pkg::POS_W-1:0]         row_index_i,
  input  logic [mm_pkg::POS_W-1:0]         col_index_i,
  input  logic signed [mm_pkg::VAL_W-1:0]  elem_value_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [mm_pkg::POS_W-1:0]         out_row_i,
  input  logic [mm_pkg::POS_W-1:0]         out_col_i,
  input  logic signed [mm_pkg::OUT_W-1:0]  out_value_i,
  input  logic                             last_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [mm_pkg::REG_W-1:0]         cfg_index_i,
  input  logic [mm_pkg::DIM_W-1:0]         cfg_data_i,
  output int                               errors_o,
  output int                               pending_o,
  output int                               elements_o
);

  typedef struct packed {
    logic [mm_pkg::POS_W-1:0]        row;
    logic [mm_pkg::POS_W-1:0]        col;
    logic signed [mm_pkg::OUT_W-1:0] value;
    logic                            last;
  } product_t;

  logic signed [mm_pkg::ELEM_WIDTH-1:0] left_elems  [mm_pkg::DEPTH];
  logic signed [mm_pkg::ELEM_WIDTH-1:0] right_elems [mm_pkg::DEPTH];
  logic [mm_pkg::DIM_W-1:0]        rows_cfg;
  logic [mm_pkg::DIM_W-1:0]        inner_cfg;
  logic [mm_pkg::DIM_W-1:0]        cols_cfg;
  product_t                        products_q [$];
  product_t                        got;
  product_t                        want;

  function automatic int dim_in_use(input logic [mm_pkg::DIM_W-1:0] d);
    if (d == '0) begin
      return 1;
    end
    if (int'(d) > mm_pkg::MAX_DIM) begin
      return mm_pkg::MAX_DIM;
    end
    return int'(d);
  endfunction

  task automatic predict_products();
    int       nr;
    int       nk;
    int       nc;
    longint   acc;
    product_t p;
    nr = dim_in_use(rows_cfg);
    nk = dim_in_use(inner_cfg);
    nc = dim_in_use(cols_cfg);
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'(left_elems[r * mm_pkg::MAX_DIM + k]) *
                 longint'(right_elems[k * mm_pkg::MAX_DIM + c]);
        end
        p.row = mm_pkg::POS_W'(r);
        p.col = mm_pkg::POS_W'(c);
        if (acc > 64'sd2147483647) begin
          p.value = 32'sh7fff_ffff;
        end else if (acc < -64'sd2147483648) begin
          p.value = 32'sh8000_0000;
        end else begin
          p.value = acc[31:0];
        end
        p.last = (r == nr - 1) && (c == nc - 1);
        products_q.push_back(p);
      end
    end
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg   = mm_pkg::DIM_RESET;
      inner_cfg  = mm_pkg::DIM_RESET;
      cols_cfg   = mm_pkg::DIM_RESET;
      errors_o   = 0;
      elements_o = 0;
      products_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{out_row_i, out_col_i, out_value_i, last_i};
        elements_o++;
        if (products_q.size() == 0) begin
          $error("unexpected product element: row %0d col %0d value %0d",
                 got.row, got.col, got.value);
          errors_o++;
        end else begin
          want = products_q.pop_front();
          check_field("out_row", want.row, got.row);
          check_field("out_col", want.col, got.col);
          check_field("out_value", want.value, got.value);
          check_field("last", want.last, got.last);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          mm_pkg::REG_LEFT_ROWS:  rows_cfg  = cfg_data_i;
          mm_pkg::REG_INNER_SIZE: inner_cfg = cfg_data_i;
          mm_pkg::REG_RIGHT_COLS: cols_cfg  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (action_i)
          mm_pkg::ACT_LEFT: begin
            left_elems[int'(row_index_i) * mm_pkg::MAX_DIM + int'(col_index_i)] =
                mm_pkg::ELEM_WIDTH'(elem_value_i);
          end
          mm_pkg::ACT_RIGHT: begin
            right_elems[int'(row_index_i) * mm_pkg::MAX_DIM + int'(col_index_i)] =
                mm_pkg::ELEM_WIDTH'(elem_value_i);
          end
          mm_pkg::ACT_COMPUTE: begin
            predict_products();
          end
          default: ;
        endcase
      end
    end
    pending_o = products_q.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for matrix_multiply. A directed opening drives full
// scale elements into both saturation limits and uses out-of-range dimension
// values; random phases then pick new dimensions, load each element that the
// next product reads if unwritten or at random, mix in stray loads and unused
// actions and compute. Both sides idle at random; product_checker checks all.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD    = 10;
  localparam int RANDOM_TARGET = 80;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = mm_pkg::MAX_DIM + 8;

  localparam logic [mm_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [mm_pkg::ACT_W-1:0] act;
    logic [mm_pkg::POS_W-1:0] row;
    logic [mm_pkg::POS_W-1:0] col;
    logic [mm_pkg::VAL_W-1:0] value;
  } request_t;

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_stall_o;
  logic [mm_pkg::ACT_W-1:0]        action_i     = '0;
  logic [mm_pkg::POS_W-1:0]        row_index_i  = '0;
  logic [mm_pkg::POS_W-1:0]        col_index_i  = '0;
  logic signed [mm_pkg::VAL_W-1:0] elem_value_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i  = 1'b0;
  logic [mm_pkg::POS_W-1:0]        out_row_o;
  logic [mm_pkg::POS_W-1:0]        out_col_o;
  logic signed [mm_pkg::OUT_W-1:0] out_value_o;
  logic                            last_o;
  logic                            cfg_valid_i  = 1'b0;
  logic                            cfg_ready_o;
  logic [mm_pkg::REG_W-1:0]        cfg_index_i  = '0;
  logic [mm_pkg::DIM_W-1:0]        cfg_data_i   = '0;

  int fail_count;
  int pending_count;
  int element_count;

  int  cycle_count    = 0;
  int  stall_hold     = 0;
  bit  no_gaps        = 1'b0;
  int  requests_sent  = 0;
  int  computes_sent  = 0;
  int  settings_count = 0;
  bit  left_written   [mm_pkg::DEPTH];
  bit  right_written  [mm_pkg::DEPTH];

  matrix_multiply u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .elem_value_i (elem_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_value_o  (out_value_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  product_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .action_i     (action_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .elem_value_i (elem_value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_i    (out_row_o),
    .out_col_i    (out_col_o),
    .out_value_i  (out_value_o),
    .last_i       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (fail_count),
    .pending_o    (pending_count),
    .elements_o   (element_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("matrix_multiply verification failed");
      $finish;
    end
  end

  // The result side holds each stall level for a random stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_hold  <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
    end
  end

  function automatic int idle_gap();
    int pick;
    if (no_gaps) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end
    if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic int dim_in_use(input logic [mm_pkg::DIM_W-1:0] d);
    if (d == '0) begin
      return 1;
    end
    if (int'(d) > mm_pkg::MAX_DIM) begin
      return mm_pkg::MAX_DIM;
    end
    return int'(d);
  endfunction

  function automatic logic [mm_pkg::DIM_W-1:0] pick_dim();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      return mm_pkg::DIM_W'($urandom_range(1, 3));
    end
    if (pick < 15) begin
      return mm_pkg::DIM_W'($urandom_range(4, 7));
    end
    if (pick == 15) begin
      return '0;
    end
    if (pick == 16) begin
      return mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
    end
    return mm_pkg::DIM_W'($urandom_range(9, 15));
  endfunction

  task automatic send_request(input request_t req);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= req.act;
    row_index_i  <= req.row;
    col_index_i  <= req.col;
    elem_value_i <= req.value;
    do @(posedge clk_i); while (in_stall_o);
    if (req.act == mm_pkg::ACT_LEFT) begin
      left_written[int'(req.row) * mm_pkg::MAX_DIM + int'(req.col)] = 1'b1;
    end else if (req.act == mm_pkg::ACT_RIGHT) begin
      right_written[int'(req.row) * mm_pkg::MAX_DIM + int'(req.col)] = 1'b1;
    end
    if (req.act != ACT_UNUSED) begin
      requests_sent++;
    end
    if (req.act == mm_pkg::ACT_COMPUTE) begin
      computes_sent++;
    end
  endtask

  task automatic send_compute();
    send_request('{mm_pkg::ACT_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom)});
  endtask

  task automatic write_dims(input logic [mm_pkg::DIM_W-1:0] rows,
                            input logic [mm_pkg::DIM_W-1:0] inner,
                            input logic [mm_pkg::DIM_W-1:0] cols);
    logic [mm_pkg::REG_W-1:0] regs [3];
    logic [mm_pkg::DIM_W-1:0] vals [3];
    regs[0] = mm_pkg::REG_LEFT_ROWS;
    regs[1] = mm_pkg::REG_INNER_SIZE;
    regs[2] = mm_pkg::REG_RIGHT_COLS;
    vals[0] = rows;
    vals[1] = inner;
    vals[2] = cols;
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    settings_count++;
  endtask

  // Waits until every predicted element has come back and the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [mm_pkg::DIM_W-1:0] rows,
                           input logic [mm_pkg::DIM_W-1:0] inner,
                           input logic [mm_pkg::DIM_W-1:0] cols);
    int       nr;
    int       nk;
    int       nc;
    int       j;
    request_t plan [$];
    request_t swap;
    nr = dim_in_use(rows);
    nk = dim_in_use(inner);
    nc = dim_in_use(cols);
    write_dims(rows, inner, cols);
    for (int r = 0; r < nr; r++) begin
      for (int k = 0; k < nk; k++) begin
        if (!left_written[r * mm_pkg::MAX_DIM + k] || $urandom_range(0, 2) == 0) begin
          plan.push_back('{mm_pkg::ACT_LEFT, 3'(r), 3'(k), 16'($urandom)});
        end
      end
    end
    for (int k = 0; k < nk; k++) begin
      for (int c = 0; c < nc; c++) begin
        if (!right_written[k * mm_pkg::MAX_DIM + c] || $urandom_range(0, 2) == 0) begin
          plan.push_back('{mm_pkg::ACT_RIGHT, 3'(k), 3'(c), 16'($urandom)});
        end
      end
    end
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        plan.push_back('{ACT_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom)});
      end else if ($urandom_range(0, 1) == 0) begin
        plan.push_back('{mm_pkg::ACT_LEFT, 3'($urandom), 3'($urandom), 16'($urandom)});
      end else begin
        plan.push_back('{mm_pkg::ACT_RIGHT, 3'($urandom), 3'($urandom), 16'($urandom)});
      end
    end
    for (int i = plan.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      swap    = plan[i];
      plan[i] = plan[j];
      plan[j] = swap;
    end
    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (plan[i]) begin
      send_request(plan[i]);
    end
    send_compute();
    if ($urandom_range(0, 3) == 0) begin
      send_compute();
    end
    no_gaps = 1'b0;
    settle();
  endtask

  initial begin
    int directed_count;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One row by one column over the full inner size: the sum of eight
    // full-scale negative squares saturates high.
    write_dims('0, 4'd15, 4'd1);
    for (int k = 0; k < mm_pkg::MAX_DIM; k++) begin
      send_request('{mm_pkg::ACT_LEFT, 3'd0, 3'(k), 16'sh8000});
    end
    for (int k = 0; k < mm_pkg::MAX_DIM; k++) begin
      send_request('{mm_pkg::ACT_RIGHT, 3'(k), 3'd0, 16'sh8000});
    end
    send_request('{ACT_UNUSED, 3'd7, 3'd7, 16'sh7fff});
    send_compute();
    settle();

    // A second column of full-scale positive elements saturates low.
    write_dims('0, 4'd15, 4'd2);
    for (int k = 0; k < mm_pkg::MAX_DIM; k++) begin
      send_request('{mm_pkg::ACT_RIGHT, 3'(k), 3'd1, 16'sh7fff});
    end
    send_compute();
    settle();
    directed_count = requests_sent;

    run_phase(4'd8, 4'd1, 4'd8);
    while (requests_sent - directed_count < RANDOM_TARGET) begin
      run_phase(pick_dim(), pick_dim(), pick_dim());
    end
    settle();

    $display("Sent %0d requests, %0d of them compute, under %0d dimension settings.",
             requests_sent, computes_sent, settings_count);
    $display("Checked %0d product elements, saturation at both limits included.",
             element_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("matrix_multiply verification clean");
    end else begin
      $display("matrix_multiply verification failed");
    end
    $finish;
  end

endmodule
